// ===== rtl/core/pcmf_pkg.sv =====
// Shared types and constants for the PCM to float32 sample converter.
// No dependencies.
package pcmf_pkg;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  localparam logic [1:0] RegIsFloat   = 2'd0;
  localparam logic [1:0] RegContainer = 2'd1;
  localparam logic [1:0] RegValid     = 2'd2;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StBadVal = 2'd1;
  localparam logic [1:0] StBadFmt = 2'd2;

  localparam logic [62:0] F32MaxAs64 = 63'h47EF_FFFF_E000_0000;

  typedef struct packed {
    logic       is_float;
    logic [6:0] container_bits;
    logic [6:0] valid_bits;
  } cfg_t;

endpackage

// ===== rtl/core/pcmf_regs.sv =====
// Configuration register file behind an APB-style port.
// Depends on pcmf_pkg.
module pcmf_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pcmf_pkg::AddrWidth-1:0] paddr,
  input  logic [pcmf_pkg::DataWidth-1:0] pwdata,
  output logic [pcmf_pkg::DataWidth-1:0] prdata,
  output logic                           pready,
  output pcmf_pkg::cfg_t                 cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.is_float       <= 1'b0;
      cfg.container_bits <= 7'd16;
      cfg.valid_bits     <= 7'd16;
    end else if (wr) begin
      unique case (paddr[3:2])
        pcmf_pkg::RegIsFloat:   cfg.is_float       <= pwdata[0];
        pcmf_pkg::RegContainer: cfg.container_bits <= pwdata[6:0];
        pcmf_pkg::RegValid:     cfg.valid_bits     <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      pcmf_pkg::RegIsFloat:   prdata = {31'd0, cfg.is_float};
      pcmf_pkg::RegContainer: prdata = {25'd0, cfg.container_bits};
      pcmf_pkg::RegValid:     prdata = {25'd0, cfg.valid_bits};
      default:                prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/pcmf_conv.sv =====
// Combinational conversion of one container word to a float32 pattern and status.
// Depends on pcmf_pkg.
module pcmf_conv (
  input  pcmf_pkg::cfg_t cfg,
  input  logic [63:0]    word,
  output logic [31:0]    float_word,
  output logic [1:0]     status
);

  logic [6:0]  cb;
  logic [6:0]  vb;
  logic        fmt_ok;
  // pcm path
  logic [31:0] sv;
  logic        neg;
  logic [31:0] mag;
  logic [4:0]  k;
  logic [31:0] mq;
  logic [4:0]  p;
  logic        nz;
  logic [4:0]  sh;
  logic [31:0] q32;
  logic [31:0] lowmask;
  logic        pg;
  logic        pst;
  logic [22:0] pfrac;
  logic [31:0] lshift;
  logic [7:0]  pexp;
  logic [30:0] pbody;
  logic [31:0] pcm_word;
  // float64 path
  logic [10:0] e;
  logic [51:0] fr;
  logic [52:0] sig;
  logic [10:0] s;
  logic [5:0]  s6;
  logic [52:0] sq;
  logic [52:0] smask;
  logic [30:0] dbody;
  logic        dg;
  logic        dst;
  logic        bad64;
  logic [31:0] d_word;
  logic        bad32;

  assign cb = cfg.container_bits;
  assign vb = cfg.valid_bits;

  always_comb begin
    if (cfg.is_float) begin
      fmt_ok = (cb == 7'd32 || cb == 7'd64) && vb == cb;
    end else begin
      fmt_ok = (cb == 7'd8 || cb == 7'd16 || cb == 7'd24 || cb == 7'd32) &&
               vb != 7'd0 && vb <= cb;
    end
  end

  always_comb begin
    unique case (cb)
      7'd8:    sv = {{25{~word[7]}}, word[6:0]};
      7'd16:   sv = {{16{word[15]}}, word[15:0]};
      7'd24:   sv = {{8{word[23]}}, word[23:0]};
      default: sv = word[31:0];
    endcase
    neg = sv[31];
    mag = neg ? (~sv + 32'd1) : sv;
    k = 5'(cb - vb);
    mq = mag >> k;
    nz = |mq;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (mq[i]) p = 5'(i);
    end
    sh = 5'd0;
    q32 = mq;
    lowmask = '0;
    pg = 1'b0;
    pst = 1'b0;
    lshift = mq << (5'd23 - p);
    pfrac = lshift[22:0];
    if (p > 5'd23) begin
      sh = p - 5'd23;
      q32 = mq >> sh;
      lowmask = (32'd1 << (sh - 5'd1)) - 32'd1;
      pg = |(mq & (32'd1 << (sh - 5'd1)));
      pst = |(mq & lowmask);
      pfrac = q32[22:0];
    end
    pexp = 8'(9'd128 + {4'd0, p} - {3'd0, vb[5:0]});
    pbody = {pexp, pfrac} + {30'd0, pg & (pst | pfrac[0])};
    pcm_word = nz ? {neg, pbody} : 32'd0;
  end

  always_comb begin
    e = word[62:52];
    fr = word[51:0];
    sig = {e != 11'd0, fr};
    s = 11'd926 - e;
    s6 = s[5:0];
    sq = '0;
    smask = '0;
    dg = 1'b0;
    dst = 1'b0;
    if (e >= 11'd897) begin
      dbody = {8'(e - 11'd896), fr[51:29]};
      dg = fr[28];
      dst = |fr[27:0];
    end else begin
      if (s > 11'd54) begin
        dbody = '0;
      end else begin
        sq = sig >> s6;
        smask = (53'd1 << (s6 - 6'd1)) - 53'd1;
        dg = |(sig & (53'd1 << (s6 - 6'd1)));
        dst = |(sig & smask);
        dbody = {8'd0, sq[22:0]};
      end
    end
    d_word = {word[63], dbody + {30'd0, dg & (dst | dbody[0])}};
    bad64 = (e == 11'h7FF) || (word[62:0] > pcmf_pkg::F32MaxAs64);
    bad32 = word[30:23] == 8'hFF;
  end

  always_comb begin
    float_word = '0;
    status = pcmf_pkg::StOk;
    if (!fmt_ok) begin
      status = pcmf_pkg::StBadFmt;
    end else if (cfg.is_float) begin
      if (cb == 7'd32) begin
        if (bad32) status = pcmf_pkg::StBadVal;
        else float_word = word[31:0];
      end else begin
        if (bad64) status = pcmf_pkg::StBadVal;
        else float_word = d_word;
      end
    end else begin
      float_word = pcm_word;
    end
  end

endmodule

// ===== rtl/core/pcm_to_float_sample_converter.sv =====
// Top level of the PCM to float32 sample converter.
// Depends on pcmf_pkg, pcmf_regs and pcmf_conv.
//
// One request in, one result out. A request is captured in an input register,
// converted by a single pass of combinational logic and stored in the result
// register, and one request is taken every cycle while the output side keeps
// up. The input register also serves as a skid stage: one request is still
// taken while a result waits under stall. Configuration registers sit at byte
// addresses 0, 4 and 8; the user must write them only while no request is in
// flight, as the block itself does not enforce this.
module pcm_to_float_sample_converter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pcmf_pkg::AddrWidth-1:0] paddr,
  input  logic [pcmf_pkg::DataWidth-1:0] pwdata,
  output logic [pcmf_pkg::DataWidth-1:0] prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [63:0]                    container_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    float_word,
  output logic [1:0]                     status
);

  pcmf_pkg::cfg_t cfg;
  logic           hold_valid;
  logic [63:0]    hold_word;
  logic           out_load;
  logic [31:0]    conv_word;
  logic [1:0]     conv_status;

  pcmf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pcmf_conv u_conv (
    .cfg        (cfg),
    .word       (hold_word),
    .float_word (conv_word),
    .status     (conv_status)
  );

  assign out_load = !out_valid || !out_stall;
  assign in_stall = hold_valid && !out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold_word <= container_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && hold_valid) begin
      float_word <= conv_word;
      status     <= conv_status;
    end
  end

endmodule
